### hw/rtl/ulfp_pkg.sv
// Shared types, character codes and hex helpers for the form body parser.
`default_nettype none

package ulfp_pkg;

  // Delimiter and escape characters
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // Most results one input item can cause
  localparam int unsigned MAX_EVENTS = 4;
  localparam int unsigned EV_IDX_W   = $clog2(MAX_EVENTS);
  localparam int unsigned EV_CNT_W   = $clog2(MAX_EVENTS + 1);

  typedef enum logic [2:0] {
    EV_KEY_BYTE   = 3'd0,
    EV_VALUE_BYTE = 3'd1,
    EV_KEY_END    = 3'd2,
    EV_FIELD_END  = 3'd3,
    EV_DONE_OK    = 3'd4,
    EV_FAILED     = 3'd5
  } event_kind_t;

  typedef enum logic [1:0] {
    PH_KEY    = 2'd0,
    PH_VALUE  = 2'd1,
    PH_DONE   = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_PERCENT = 2'd1,
    ESC_DIGIT   = 2'd2
  } esc_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
  } event_t;

  // True for 0-9, a-f, A-F
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Nibble value of a hex digit; letters differ from digits in the low bits by 9
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) v = c[3:0];
    else            v = c[3:0] + 4'd9;
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/urlencoded_form_parser_core.sv
// Top level: streaming percent-decoding parser for form bodies.
//
// Input channel (in_valid/in_ready): command selects a body byte (0) or the
// end of the body (1); data_byte carries the raw byte. Output channel
// (out_valid/out_ready) carries event_kind, out_byte and last_result, which
// marks the final event caused by one input transfer.
//
// Each input transfer is decoded into a batch of zero to four events held
// in a small result register; the batch is then drained one event per
// cycle while out_ready is high. The first event appears on the output in
// the cycle after its input transfer. A new input is taken in the same
// cycle as the last event of the previous batch, so a byte that gives at
// most one event sustains one input per cycle while out_ready is high; a
// byte closing a malformed escape gives up to three events and the end
// command up to four. A done or failed body takes inputs and drops them.
//
// Reset returns the parser to key phase with no escape pending and empties
// the result register. When the receiver stalls, the current event holds
// and input is refused until the last pending event is being taken.
`default_nettype none

module urlencoded_form_parser_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      event_kind,
  output logic [7:0]      out_byte,
  output logic            last_result
);

  // Parser state
  ulfp_pkg::phase_t phase, phase_next;
  ulfp_pkg::esc_t   esc, esc_next;
  logic [7:0]       held, held_next;

  // Result batch
  ulfp_pkg::event_t                   batch [ulfp_pkg::MAX_EVENTS];
  ulfp_pkg::event_t                   ev_next [ulfp_pkg::MAX_EVENTS];
  logic [ulfp_pkg::EV_CNT_W-1:0]      remain;
  logic [ulfp_pkg::EV_IDX_W-1:0]      rd_ptr;
  logic [ulfp_pkg::EV_CNT_W-1:0]      n_next;

  logic in_xfer, out_xfer;

  assign out_valid = (remain != '0);
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = (remain == '0) ||
                     ((remain == ulfp_pkg::EV_CNT_W'(1)) && out_ready);
  assign in_xfer   = in_valid && in_ready;

  assign event_kind  = batch[rd_ptr].kind;
  assign out_byte    = batch[rd_ptr].data;
  assign last_result = (remain == ulfp_pkg::EV_CNT_W'(1));

  // Decode one input into next state and an event batch
  always_comb begin
    ulfp_pkg::event_kind_t byte_kind;
    logic [7:0]            delim;
    logic                  hex_ok;
    logic                  handle;
    phase_next = phase;
    esc_next   = esc;
    held_next  = held;
    n_next     = '0;
    handle     = 1'b1;
    for (int i = 0; i < ulfp_pkg::MAX_EVENTS; i++) begin
      ev_next[i] = '{kind: ulfp_pkg::EV_KEY_BYTE, data: 8'h00};
    end
    byte_kind = (phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::EV_KEY_BYTE
                                            : ulfp_pkg::EV_VALUE_BYTE;
    delim     = (phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::CH_EQUALS : ulfp_pkg::CH_AMP;
    hex_ok    = ulfp_pkg::is_hex(data_byte);

    if ((phase == ulfp_pkg::PH_DONE) || (phase == ulfp_pkg::PH_FAILED)) begin
      // body closed: drop input
    end else if (!command) begin
      // close a pending escape
      if (esc == ulfp_pkg::ESC_PERCENT) begin
        if (hex_ok) begin
          held_next = data_byte;
          esc_next  = ulfp_pkg::ESC_DIGIT;
          handle    = 1'b0;
        end else begin
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: byte_kind,
                                                      data: ulfp_pkg::CH_PERCENT};
          n_next   = n_next + 1'b1;
          esc_next = ulfp_pkg::ESC_NONE;
        end
      end else if (esc == ulfp_pkg::ESC_DIGIT) begin
        esc_next  = ulfp_pkg::ESC_NONE;
        held_next = 8'h00;
        if (hex_ok) begin
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] =
            '{kind: byte_kind, data: {ulfp_pkg::hex_val(held), ulfp_pkg::hex_val(data_byte)}};
          n_next = n_next + 1'b1;
          handle = 1'b0;
        end else begin
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: byte_kind,
                                                      data: ulfp_pkg::CH_PERCENT};
          n_next = n_next + 1'b1;
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: byte_kind, data: held};
          n_next = n_next + 1'b1;
        end
      end
      // the byte itself
      if (handle) begin
        if (data_byte == delim) begin
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] =
            '{kind: (phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::EV_KEY_END
                                                : ulfp_pkg::EV_FIELD_END,
              data: 8'h00};
          n_next     = n_next + 1'b1;
          phase_next = (phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::PH_VALUE : ulfp_pkg::PH_KEY;
        end else if (data_byte == ulfp_pkg::CH_PERCENT) begin
          esc_next = ulfp_pkg::ESC_PERCENT;
        end else begin
          ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: byte_kind, data: data_byte};
          n_next = n_next + 1'b1;
        end
      end
    end else if (phase == ulfp_pkg::PH_KEY) begin
      // end of body with an open key
      ev_next[0] = '{kind: ulfp_pkg::EV_FAILED, data: 8'h00};
      n_next     = ulfp_pkg::EV_CNT_W'(1);
      phase_next = ulfp_pkg::PH_FAILED;
      esc_next   = ulfp_pkg::ESC_NONE;
      held_next  = 8'h00;
    end else begin
      // end of body with an open value: flush escape, close field, finish
      if (esc == ulfp_pkg::ESC_PERCENT) begin
        ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: ulfp_pkg::EV_VALUE_BYTE,
                                                    data: ulfp_pkg::CH_PERCENT};
        n_next = n_next + 1'b1;
      end else if (esc == ulfp_pkg::ESC_DIGIT) begin
        ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: ulfp_pkg::EV_VALUE_BYTE,
                                                    data: ulfp_pkg::CH_PERCENT};
        n_next = n_next + 1'b1;
        ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: ulfp_pkg::EV_VALUE_BYTE,
                                                    data: held};
        n_next = n_next + 1'b1;
      end
      ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: ulfp_pkg::EV_FIELD_END, data: 8'h00};
      n_next = n_next + 1'b1;
      ev_next[n_next[ulfp_pkg::EV_IDX_W-1:0]] = '{kind: ulfp_pkg::EV_DONE_OK, data: 8'h00};
      n_next     = n_next + 1'b1;
      phase_next = ulfp_pkg::PH_DONE;
      esc_next   = ulfp_pkg::ESC_NONE;
      held_next  = 8'h00;
    end
  end

  // Parser state and batch control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= ulfp_pkg::PH_KEY;
      esc    <= ulfp_pkg::ESC_NONE;
      held   <= 8'h00;
      remain <= '0;
      rd_ptr <= '0;
    end else if (in_xfer) begin
      phase  <= phase_next;
      esc    <= esc_next;
      held   <= held_next;
      remain <= n_next;
      rd_ptr <= '0;
    end else if (out_xfer) begin
      remain <= remain - 1'b1;
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Batch payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < ulfp_pkg::MAX_EVENTS; i++) begin
        batch[i] <= ev_next[i];
      end
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the streaming form body parser core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [7:0] CH_PLAIN = 8'h78;  // 'x', neither hex nor delimiter

  // One decoded event as the core should report it
  typedef struct packed {
    ulfp_pkg::event_kind_t kind;
    logic [7:0]            data;
    logic                  last;
  } parse_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_kind;
  logic [7:0] out_byte;
  logic       last_result;

  // Parser state mirrored by the predictor
  ulfp_pkg::phase_t pred_phase;
  ulfp_pkg::esc_t   pred_esc;
  logic [7:0]       pred_held;

  // Events of the transfer being decoded, then the queue of pending ones
  ulfp_pkg::event_kind_t batch_kind [0:3];
  logic [7:0]            batch_data [0:3];
  int                    batch_n;
  parse_event_t          expected_events [$];
  parse_event_t          got_ev;

  int  error_count = 0;
  int  items_sent = 0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  int  stall_left = 0;

  urlencoded_form_parser_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .out_byte    (out_byte),
    .last_result (last_result)
  );

  always #4 clk = ~clk;

  // Prints one mismatch line and counts it
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Hex digit value, or -1 for any other byte
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(32'h30 + r);
    if (r < 16) return 8'(32'h61 + r - 10);
    return 8'(32'h41 + r - 16);
  endfunction

  task automatic add_event(input ulfp_pkg::event_kind_t kind, input logic [7:0] data);
    batch_kind[batch_n] = kind;
    batch_data[batch_n] = data;
    batch_n++;
  endtask

  // An unfinished escape goes out raw in the given kind
  task automatic flush_escape(input ulfp_pkg::event_kind_t kind);
    if (pred_esc != ulfp_pkg::ESC_NONE) add_event(kind, ulfp_pkg::CH_PERCENT);
    if (pred_esc == ulfp_pkg::ESC_DIGIT) add_event(kind, pred_held);
    pred_esc  = ulfp_pkg::ESC_NONE;
    pred_held = 8'h00;
  endtask

  // Expected events for one accepted input transfer
  task automatic decode_transfer(input logic cmd, input logic [7:0] c);
    ulfp_pkg::event_kind_t byte_kind;
    logic [7:0]            delim;
    int                    hv;
    int                    hi;
    batch_n = 0;
    if (pred_phase == ulfp_pkg::PH_KEY || pred_phase == ulfp_pkg::PH_VALUE) begin
      byte_kind = (pred_phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::EV_KEY_BYTE
                                                   : ulfp_pkg::EV_VALUE_BYTE;
      delim     = (pred_phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::CH_EQUALS : ulfp_pkg::CH_AMP;
      hv        = nibble_of(c);
      if (cmd) begin
        if (pred_phase == ulfp_pkg::PH_KEY) begin
          // open key at end of body: pending escape is dropped
          add_event(ulfp_pkg::EV_FAILED, 8'h00);
          pred_phase = ulfp_pkg::PH_FAILED;
          pred_esc   = ulfp_pkg::ESC_NONE;
          pred_held  = 8'h00;
        end else begin
          flush_escape(ulfp_pkg::EV_VALUE_BYTE);
          add_event(ulfp_pkg::EV_FIELD_END, 8'h00);
          add_event(ulfp_pkg::EV_DONE_OK, 8'h00);
          pred_phase = ulfp_pkg::PH_DONE;
        end
      end else if (pred_esc == ulfp_pkg::ESC_PERCENT && hv >= 0) begin
        pred_held = c;
        pred_esc  = ulfp_pkg::ESC_DIGIT;
      end else if (pred_esc == ulfp_pkg::ESC_DIGIT && hv >= 0) begin
        hi = nibble_of(pred_held);
        add_event(byte_kind, {hi[3:0], hv[3:0]});
        pred_esc  = ulfp_pkg::ESC_NONE;
        pred_held = 8'h00;
      end else begin
        // broken escape flushes, then the byte is handled afresh
        flush_escape(byte_kind);
        if (c == delim) begin
          add_event((pred_phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::EV_KEY_END
                                                     : ulfp_pkg::EV_FIELD_END, 8'h00);
          pred_phase = (pred_phase == ulfp_pkg::PH_KEY) ? ulfp_pkg::PH_VALUE
                                                        : ulfp_pkg::PH_KEY;
        end else if (c == ulfp_pkg::CH_PERCENT) begin
          pred_esc = ulfp_pkg::ESC_PERCENT;
        end else begin
          add_event(byte_kind, c);
        end
      end
    end
    for (int i = 0; i < batch_n; i++) begin
      expected_events.push_back('{kind: batch_kind[i], data: batch_data[i],
                                  last: (i == batch_n - 1)});
    end
  endtask

  // Sends one item; called at a rising edge, returns at its transfer edge
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_transfer(cmd, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  // Extremes, delimiters in both phases, good and broken escapes
  task automatic test_directed();
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    // '&' is plain in a key; bad escapes after '%' and after one digit;
    // a second '%' restarts the escape; an escape open at '='
    send_text("&%41%g%az%%41%F=");
    // '=' and '+' are plain in a value; escape open at '&'
    send_text("=+%fF%&");
    // empty key and empty value
    send_text("=&");
  endtask

  // Mostly well-formed fields with random content, some noise
  task automatic test_random_fields(input int count);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (items_sent > stop_at - 40) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      r = $urandom_range(0, 19);
      if (r < 9) begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (r < 14) begin
        send_item(1'b0, ulfp_pkg::CH_PERCENT);
        send_item(1'b0, rand_hex_digit());
        send_item(1'b0, rand_hex_digit());
      end else if (r < 17) begin
        send_item(1'b0, ($urandom_range(0, 1) != 0) ? ulfp_pkg::CH_EQUALS
                                                    : ulfp_pkg::CH_AMP);
      end else begin
        send_item(1'b0, ulfp_pkg::CH_PERCENT);
        if ($urandom_range(0, 1) != 0) send_item(1'b0, rand_hex_digit());
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Close the body in a random phase, at random with an escape left open
  task automatic test_end_of_body();
    bit want_value;
    int want_esc;
    want_value = 1'($urandom_range(0, 1));
    want_esc   = int'($urandom_range(0, 2));
    if (want_value && pred_phase == ulfp_pkg::PH_KEY) send_item(1'b0, ulfp_pkg::CH_EQUALS);
    if (!want_value && pred_phase == ulfp_pkg::PH_VALUE) send_item(1'b0, ulfp_pkg::CH_AMP);
    if (pred_esc != ulfp_pkg::ESC_NONE) send_item(1'b0, CH_PLAIN);
    if (want_esc >= 1) send_item(1'b0, ulfp_pkg::CH_PERCENT);
    if (want_esc == 2) send_item(1'b0, rand_hex_digit());
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Everything after the end of body must be dropped silently
  task automatic test_after_end();
    for (int i = 0; i < 6; i++) begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver readiness with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected event
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d byte %02h",
                                  event_kind, out_byte));
      end else begin
        got_ev = expected_events.pop_front();
        if (event_kind !== got_ev.kind)
          report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, got_ev.kind));
        if (out_byte !== got_ev.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, got_ev.data));
        if (last_result !== got_ev.last)
          report_mismatch($sformatf("last_result %0b, want %0b", last_result, got_ev.last));
      end
    end
  end

  initial begin
    pred_phase = ulfp_pkg::PH_KEY;
    pred_esc   = ulfp_pkg::ESC_NONE;
    pred_held  = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // now and then the body is empty, so the rest must be ignored
    if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
    test_directed();
    test_random_fields(75);
    test_end_of_body();
    test_after_end();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### urlencoded_form_parser_core.f
hw/rtl/ulfp_pkg.sv
hw/rtl/urlencoded_form_parser_core.sv
tb/tb_top.sv
